[src/pprq_pkg.sv]
// Shared types and constants for the process priority ready queue.
// No dependencies; imported by process_priority_ready_queue and pprq_checker.
`default_nettype none

package pprq_pkg;

  localparam int CAPACITY = 64;
  localparam int PID_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;

  typedef enum logic [1:0] {
    CMD_ENQUEUE    = 2'd0,
    CMD_DEQ_HEAD   = 2'd1,
    CMD_DEQ_TAIL   = 2'd2,
    CMD_REMOVE_PID = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_ERR   = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t                    command;
    logic [7:0]              proc_id;
    logic signed [KEY_W-1:0] priority_key;
  } cmd_item_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] result_pid;
    logic [6:0] entry_count;
    logic       is_empty;
    logic       is_full;
  } rsp_item_t;

  typedef struct packed {
    logic [PID_W-1:0]        pid;
    logic signed [KEY_W-1:0] key;
  } entry_t;

endpackage

`default_nettype wire

[src/pprq_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module pprq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/process_priority_ready_queue.sv]
// Top level of the process priority ready queue: sequencer, entry RAM and result register.
// Depends on pprq_pkg and pprq_ram.
//
//   Channel   Handshake               Payload      Role
//   command   cmd_valid / cmd_ready   cmd_item     one enqueue or remove request
//   response  rsp_valid / rsp_ready   rsp_item     one status item per command
//
// Entries live in a single RAM, head at address 0. All work goes through its one read
// and one write port, one entry per cycle, so the RAM port sets the pace: enqueue
// moves one step per entry it passes, remove-head shifts every remaining entry up,
// remove-tail reads the tail only, and remove-by-pid checks head and tail, then scans
// the interior and closes the gap.
// Errors and empty end the command as soon as they are found.
// Reset clears the occupancy, the sequencer and rsp_valid; RAM contents are left as they are.
// A finished item waits in the result register while the next command is taken.
`default_nettype none

module process_priority_ready_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  output logic                      cmd_ready,
  input  wire pprq_pkg::cmd_item_t  cmd_item,
  output logic                      rsp_valid,
  input  wire logic                 rsp_ready,
  output pprq_pkg::rsp_item_t       rsp_item
);

  import pprq_pkg::*;

  localparam int AW = PID_W;

  // Sequencer states, one-hot.
  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_INSERT   = 10'b00_0000_0010,
    S_PLACE    = 10'b00_0000_0100,
    S_HEAD     = 10'b00_0000_1000,
    S_TAIL     = 10'b00_0001_0000,
    S_CHK_HEAD = 10'b00_0010_0000,
    S_CHK_TAIL = 10'b00_0100_0000,
    S_SCAN     = 10'b00_1000_0000,
    S_SHIFT    = 10'b01_0000_0000,
    S_FINISH   = 10'b10_0000_0000
  } state_t;

  state_t                  state;
  logic [CNT_W-1:0]        occ;
  logic [CNT_W-1:0]        pos;
  logic [7:0]              pid;
  logic signed [KEY_W-1:0] key;
  logic [7:0]              rpid;
  status_t                 status;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  entry_t                  ram_wdata;
  logic [AW-1:0]           ram_raddr;
  entry_t                  rd_entry;

  logic [CNT_W-1:0]        occ_m1;
  logic [CNT_W-1:0]        pos_m1;
  logic [CNT_W-1:0]        pos_m2;
  logic [CNT_W-1:0]        pos_p1;
  logic [CNT_W-1:0]        pos_p2;
  logic                    pid_hit;
  logic                    key_lower;
  logic                    pid_bad;
  logic                    enq_bad;
  logic                    cmd_fire;
  entry_t                  new_entry;

  assign cmd_ready = (state == S_IDLE);
  assign cmd_fire  = cmd_valid && cmd_ready;

  assign occ_m1 = occ - CNT_W'(1);
  assign pos_m1 = pos - CNT_W'(1);
  assign pos_m2 = pos - CNT_W'(2);
  assign pos_p1 = pos + CNT_W'(1);
  assign pos_p2 = pos + CNT_W'(2);

  // The single shared compare unit: pid match and signed key order on the entry just read.
  assign pid_hit   = (rd_entry.pid == pid[AW-1:0]);
  assign key_lower = ($signed(rd_entry.key) < $signed(key));

  assign pid_bad = (32'(cmd_item.proc_id) >= CAPACITY);
  assign enq_bad = pid_bad || (32'(occ) >= CAPACITY);

  assign new_entry.pid = pid[AW-1:0];
  assign new_entry.key = key;

  pprq_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(CAPACITY)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rd_entry)
  );

  // RAM port control. A read issued in one state delivers its data in the next one,
  // so every state whose successor uses an entry reads that entry ahead.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos[AW-1:0];
    ram_wdata = rd_entry;
    ram_raddr = '0;
    unique case (state)
      S_IDLE: begin
        if (cmd_item.command == CMD_ENQUEUE || cmd_item.command == CMD_DEQ_TAIL) begin
          ram_raddr = occ_m1[AW-1:0];
        end
        // Insertion into an empty queue needs no walk.
        if (cmd_fire && cmd_item.command == CMD_ENQUEUE && !enq_bad && occ == '0) begin
          ram_we          = 1'b1;
          ram_waddr       = '0;
          ram_wdata.pid   = cmd_item.proc_id[AW-1:0];
          ram_wdata.key   = cmd_item.priority_key;
        end
      end
      S_INSERT: begin
        ram_we = 1'b1;
        if (key_lower) begin
          ram_raddr = pos_m2[AW-1:0];
        end else begin
          ram_wdata = new_entry;
        end
      end
      S_PLACE: begin
        ram_we    = 1'b1;
        ram_wdata = new_entry;
      end
      S_HEAD: begin
        ram_raddr = AW'(1);
      end
      S_CHK_HEAD: begin
        ram_raddr = pid_hit ? AW'(1) : occ_m1[AW-1:0];
      end
      S_CHK_TAIL: begin
        ram_raddr = AW'(1);
      end
      S_SCAN: begin
        ram_raddr = pos_p1[AW-1:0];
      end
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_raddr = pos_p2[AW-1:0];
      end
      S_TAIL, S_FINISH: begin
        ram_raddr = '0;
      end
      default: begin
        ram_raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // In the finish state the result register is reloaded instead.
      if (rsp_valid && rsp_ready && state != S_FINISH) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            pid    <= cmd_item.proc_id;
            key    <= cmd_item.priority_key;
            rpid   <= '0;
            status <= ST_OK;
            if (cmd_item.command == CMD_ENQUEUE) begin
              if (enq_bad) begin
                status <= ST_ERR;
                state  <= S_FINISH;
              end else if (occ == '0) begin
                occ   <= CNT_W'(1);
                rpid  <= cmd_item.proc_id;
                state <= S_FINISH;
              end else begin
                pos   <= occ;
                state <= S_INSERT;
              end
            end else if (occ == '0) begin
              // Empty is reported before any other check of a remove.
              status <= ST_EMPTY;
              state  <= S_FINISH;
            end else begin
              unique case (cmd_item.command)
                CMD_DEQ_HEAD: state <= S_HEAD;
                CMD_DEQ_TAIL: state <= S_TAIL;
                CMD_REMOVE_PID: begin
                  if (pid_bad) begin
                    status <= ST_ERR;
                    state  <= S_FINISH;
                  end else begin
                    state <= S_CHK_HEAD;
                  end
                end
                default: state <= S_FINISH;
              endcase
            end
          end
        end
        S_INSERT: begin
          // Walk toward the head while the entry ahead has a strictly lower key.
          if (key_lower) begin
            pos <= pos_m1;
            if (pos_m1 == '0) begin
              state <= S_PLACE;
            end
          end else begin
            occ   <= occ + CNT_W'(1);
            rpid  <= pid;
            state <= S_FINISH;
          end
        end
        S_PLACE: begin
          occ   <= occ + CNT_W'(1);
          rpid  <= pid;
          state <= S_FINISH;
        end
        S_HEAD: begin
          rpid <= 8'(rd_entry.pid);
          if (occ_m1 != '0) begin
            pos   <= '0;
            state <= S_SHIFT;
          end else begin
            occ   <= occ_m1;
            state <= S_FINISH;
          end
        end
        S_TAIL: begin
          rpid  <= 8'(rd_entry.pid);
          occ   <= occ_m1;
          state <= S_FINISH;
        end
        S_CHK_HEAD: begin
          if (pid_hit) begin
            rpid <= pid;
            if (occ_m1 != '0) begin
              pos   <= '0;
              state <= S_SHIFT;
            end else begin
              occ   <= occ_m1;
              state <= S_FINISH;
            end
          end else if (occ_m1 == '0) begin
            status <= ST_ERR;
            state  <= S_FINISH;
          end else begin
            state <= S_CHK_TAIL;
          end
        end
        S_CHK_TAIL: begin
          if (pid_hit) begin
            rpid  <= pid;
            occ   <= occ_m1;
            state <= S_FINISH;
          end else if (occ_m1 == CNT_W'(1)) begin
            status <= ST_ERR;
            state  <= S_FINISH;
          end else begin
            pos   <= CNT_W'(1);
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Interior entries are searched from the head; the first match is taken.
          if (pid_hit) begin
            rpid  <= pid;
            state <= S_SHIFT;
          end else if (pos_p1 == occ_m1) begin
            status <= ST_ERR;
            state  <= S_FINISH;
          end else begin
            pos <= pos_p1;
          end
        end
        S_SHIFT: begin
          // Each cycle moves one entry up by one slot to close the gap.
          if (pos_p1 == occ_m1) begin
            occ   <= occ_m1;
            state <= S_FINISH;
          end else begin
            pos <= pos_p1;
          end
        end
        S_FINISH: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid            <= 1'b1;
            rsp_item.status      <= status;
            rsp_item.result_pid  <= rpid;
            rsp_item.entry_count <= 7'(occ);
            rsp_item.is_empty    <= (occ == '0);
            rsp_item.is_full     <= (32'(occ) >= CAPACITY);
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[src/pprq_checker.sv]
// Port-level checks on the response channel of the ready queue, bound to the top level.
// Depends on pprq_pkg and process_priority_ready_queue.
`default_nettype none

module pprq_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                rsp_valid,
  input wire logic                rsp_ready,
  input wire pprq_pkg::rsp_item_t rsp_item
);

  import pprq_pkg::*;

  a_empty_flag : assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_item.is_empty == (rsp_item.entry_count == '0)))
    else $error("is_empty disagrees with entry_count");

  a_full_flag : assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_item.is_full == (32'(rsp_item.entry_count) == CAPACITY)))
    else $error("is_full disagrees with entry_count");

  a_empty_status : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_item.status == ST_EMPTY) |-> rsp_item.is_empty)
    else $error("empty status on a queue that holds entries");

  a_pid_on_fail : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_item.status != ST_OK) |-> (rsp_item.result_pid == '0))
    else $error("failed command reports a pid");

  a_hold : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_item)))
    else $error("stalled response item changed");

endmodule

bind process_priority_ready_queue pprq_checker u_pprq_checker (
  .clk      (clk),
  .rst      (rst),
  .rsp_valid(rsp_valid),
  .rsp_ready(rsp_ready),
  .rsp_item (rsp_item)
);

`default_nettype wire
